// File: hdl/gf3nc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gf3nc_pkg
// Types and constants shared by the GF(2^8) three-symbol network coder.
// ----------------------------------------------------------------------------
package gf3nc_pkg;

  localparam int unsigned SymW  = 8;
  localparam int unsigned RowW  = 3 * SymW;
  localparam int unsigned CfgIdxW = 3;

  // register indexes of the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    REG_FIELD_POLY = 3'd0,
    REG_COEF_ROW0  = 3'd1,
    REG_COEF_ROW1  = 3'd2,
    REG_COEF_ROW2  = 3'd3
  } cfg_reg_e;

  localparam logic [SymW-1:0] FieldPolyRst = 8'h1d;
  localparam logic [RowW-1:0] CoefRow0Rst  = 24'h010000;
  localparam logic [RowW-1:0] CoefRow1Rst  = 24'h000100;
  localparam logic [RowW-1:0] CoefRow2Rst  = 24'h000001;

  typedef struct packed {
    logic [SymW-1:0] byte_a;
    logic [SymW-1:0] byte_b;
    logic [SymW-1:0] byte_c;
    logic            last_in;
  } in_item_t;

  typedef struct packed {
    logic [SymW-1:0] coded_a;
    logic [SymW-1:0] coded_b;
    logic [SymW-1:0] coded_c;
    logic            last_out;
  } out_item_t;

  // one coefficient row: c0 scales byte_a, c1 byte_b, c2 byte_c
  typedef struct packed {
    logic [SymW-1:0] c0;
    logic [SymW-1:0] c1;
    logic [SymW-1:0] c2;
  } coef_row_t;

endpackage
`default_nettype wire

// File: hdl/gf256_three_symbol_network_coder_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gf256_three_symbol_network_coder_top
// Three-symbol linear network coder over GF(2^8), one byte offset per item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_data_i) carries the bytes at
//   one offset of three source packets plus the last flag. Output channel
//   (out_valid_o / out_ready_i / out_data_o) returns the three coded bytes
//   and the last flag copied through. Both channels are valid/ready.
//   Datapath: input register -> nine GF multipliers and XOR trees -> result
//   register. out_valid_o rises once an accepted item has passed the input
//   register and its coded result has been loaded into the result register.
//   Throughput is one item per cycle while the receiver takes results; the
//   input register and the result register form a two-entry pipeline, so
//   the block can take one more item while a finished result waits.
//   Receiver stall: the result register holds its item; the input register
//   can still take one more item, after which in_ready_o drops until the
//   receiver takes the result. in_ready_o is high whenever out_ready_i is.
//   Config port: cfg_we_i writes cfg_data_i into register cfg_idx_i
//   (0 field polynomial low byte, 1..3 coefficient rows); other indexes are
//   ignored. Write only while the block is idle.
//   Reset: pipeline empties, registers return to polynomial 0x1d and the
//   identity matrix.
// ----------------------------------------------------------------------------
module gf256_three_symbol_network_coder_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration
  input  wire logic                          cfg_we_i,
  input  wire logic [gf3nc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [gf3nc_pkg::RowW-1:0]    cfg_data_i,
  // input items
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire gf3nc_pkg::in_item_t           in_data_i,
  // result items
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output gf3nc_pkg::out_item_t               out_data_o
);

  // configuration registers
  logic [gf3nc_pkg::SymW-1:0] poly_q;
  gf3nc_pkg::coef_row_t       row0_q, row1_q, row2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q <= gf3nc_pkg::FieldPolyRst;
      row0_q <= gf3nc_pkg::CoefRow0Rst;
      row1_q <= gf3nc_pkg::CoefRow1Rst;
      row2_q <= gf3nc_pkg::CoefRow2Rst;
    end else if (cfg_we_i) begin
      case (gf3nc_pkg::cfg_reg_e'(cfg_idx_i))
        gf3nc_pkg::REG_FIELD_POLY: poly_q <= cfg_data_i[gf3nc_pkg::SymW-1:0];
        gf3nc_pkg::REG_COEF_ROW0:  row0_q <= cfg_data_i;
        gf3nc_pkg::REG_COEF_ROW1:  row1_q <= cfg_data_i;
        gf3nc_pkg::REG_COEF_ROW2:  row2_q <= cfg_data_i;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // pipeline control
  logic                 in_vld_q, in_vld_d;
  logic                 res_vld_q, res_vld_d;
  gf3nc_pkg::in_item_t  in_item_q;
  gf3nc_pkg::out_item_t res_item_q, res_item_d;
  logic                 res_load, in_load;

  // result register takes the stage-1 item when empty or being drained
  assign res_load   = in_vld_q && (!res_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || res_load;
  assign in_load    = in_valid_i && in_ready_o;

  always_comb begin
    in_vld_d  = in_vld_q;
    res_vld_d = res_vld_q;
    if (in_load) begin
      in_vld_d = 1'b1;
    end else if (res_load) begin
      in_vld_d = 1'b0;
    end
    if (res_load) begin
      res_vld_d = 1'b1;
    end else if (out_ready_i) begin
      res_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      res_vld_q <= res_vld_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_item_q <= in_data_i;
    end
    if (res_load) begin
      res_item_q <= res_item_d;
    end
  end

  // coding datapath: one row unit per coded byte
  gf3nc_row u_row0 (
    .poly_i (poly_q), .row_i (row0_q),
    .sym_a_i(in_item_q.byte_a), .sym_b_i(in_item_q.byte_b), .sym_c_i(in_item_q.byte_c),
    .coded_o(res_item_d.coded_a)
  );

  gf3nc_row u_row1 (
    .poly_i (poly_q), .row_i (row1_q),
    .sym_a_i(in_item_q.byte_a), .sym_b_i(in_item_q.byte_b), .sym_c_i(in_item_q.byte_c),
    .coded_o(res_item_d.coded_b)
  );

  gf3nc_row u_row2 (
    .poly_i (poly_q), .row_i (row2_q),
    .sym_a_i(in_item_q.byte_a), .sym_b_i(in_item_q.byte_b), .sym_c_i(in_item_q.byte_c),
    .coded_o(res_item_d.coded_c)
  );

  assign res_item_d.last_out = in_item_q.last_in;

  assign out_valid_o = res_vld_q;
  assign out_data_o  = res_item_q;

endmodule
`default_nettype wire

// File: hdl/gf3nc_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gf3nc_mul
// GF(2^8) shift-and-add multiplier, reduction polynomial x^8 + poly_i.
// ----------------------------------------------------------------------------
module gf3nc_mul (
  input  wire logic [gf3nc_pkg::SymW-1:0] poly_i,
  input  wire logic [gf3nc_pkg::SymW-1:0] coef_i,
  input  wire logic [gf3nc_pkg::SymW-1:0] data_i,
  output logic      [gf3nc_pkg::SymW-1:0] prod_o
);

  always_comb begin
    logic [gf3nc_pkg::SymW-1:0] acc;
    logic [gf3nc_pkg::SymW-1:0] x;
    acc = '0;
    x   = data_i;
    for (int k = 0; k < gf3nc_pkg::SymW; k++) begin
      if (coef_i[k]) begin
        acc = acc ^ x;
      end
      // multiply by alpha: shift and fold the carried-out bit back in
      if (x[gf3nc_pkg::SymW-1]) begin
        x = {x[gf3nc_pkg::SymW-2:0], 1'b0} ^ poly_i;
      end else begin
        x = {x[gf3nc_pkg::SymW-2:0], 1'b0};
      end
    end
    prod_o = acc;
  end

endmodule
`default_nettype wire

// File: hdl/gf3nc_row.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gf3nc_row
// One coded byte: XOR of three GF(2^8) products of a coefficient row.
// ----------------------------------------------------------------------------
module gf3nc_row (
  input  wire logic [gf3nc_pkg::SymW-1:0] poly_i,
  input  wire gf3nc_pkg::coef_row_t       row_i,
  input  wire logic [gf3nc_pkg::SymW-1:0] sym_a_i,
  input  wire logic [gf3nc_pkg::SymW-1:0] sym_b_i,
  input  wire logic [gf3nc_pkg::SymW-1:0] sym_c_i,
  output logic      [gf3nc_pkg::SymW-1:0] coded_o
);

  logic [gf3nc_pkg::SymW-1:0] prod_a, prod_b, prod_c;

  gf3nc_mul u_mul_a (.poly_i(poly_i), .coef_i(row_i.c0), .data_i(sym_a_i), .prod_o(prod_a));
  gf3nc_mul u_mul_b (.poly_i(poly_i), .coef_i(row_i.c1), .data_i(sym_b_i), .prod_o(prod_b));
  gf3nc_mul u_mul_c (.poly_i(poly_i), .coef_i(row_i.c2), .data_i(sym_c_i), .prod_o(prod_c));

  assign coded_o = prod_a ^ prod_b ^ prod_c;

endmodule
`default_nettype wire

// File: hdl/gf3nc_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gf3nc_checker
// Port-level assertions for the network coder top, attached by bind.
// ----------------------------------------------------------------------------
module gf3nc_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_ready_o,
  input wire logic                          out_valid_o,
  input wire logic                          out_ready_i,
  input wire gf3nc_pkg::out_item_t          out_data_o
);

  // a fresh result appears only for an item that was taken and has passed the input and result registers
  a_rise_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result appeared without an item accepted two cycles before");

  // a draining receiver never blocks the input side
  a_ready_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("in_ready_o low while out_ready_i high");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("out_valid_o dropped before accept");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("out_data_o changed while stalled");

endmodule

bind gf256_three_symbol_network_coder_top gf3nc_checker u_gf3nc_checker (.*);
`default_nettype wire

// File: tb/tb_gf256_three_symbol_network_coder_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gf256_three_symbol_network_coder_top
// Self-checking bench for the GF(2^8) three-symbol network coder: a mirror
// of the coefficient matrix and field polynomial predicts each coded item,
// and results are checked in order under random idling on both channels.
// ----------------------------------------------------------------------------
module tb_gf256_three_symbol_network_coder_top;

  // Cycles without any handshake before the run is declared hung. The longest
  // legal quiet stretch is the forced receiver hold (HoldCycles) or a run of
  // receiver idles at 81%, both far below this.
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned HoldCycles = 120;
  localparam int unsigned ChunkItems = 110;
  // Indexes above the last coefficient row decode to nothing.
  localparam logic [gf3nc_pkg::CfgIdxW-1:0] RegSpareLo = 3'd4;

  // --------------------------------------------------------------------------
  // Mirror of the coder: register copies, GF(2^8) math, expected items in order
  // --------------------------------------------------------------------------
  class gf3_coder_mirror;
    logic [gf3nc_pkg::SymW-1:0] poly;
    gf3nc_pkg::coef_row_t       rows [3];
    gf3nc_pkg::out_item_t       coded_q [$];
    int unsigned                errors;
    int unsigned                checked;

    function new();
      poly    = gf3nc_pkg::FieldPolyRst;
      rows[0] = gf3nc_pkg::CoefRow0Rst;
      rows[1] = gf3nc_pkg::CoefRow1Rst;
      rows[2] = gf3nc_pkg::CoefRow2Rst;
      errors  = 0;
      checked = 0;
    endfunction

    function void write_reg(logic [gf3nc_pkg::CfgIdxW-1:0] idx,
                            logic [gf3nc_pkg::RowW-1:0] data);
      case (idx)
        gf3nc_pkg::REG_FIELD_POLY: poly = data[gf3nc_pkg::SymW-1:0];
        gf3nc_pkg::REG_COEF_ROW0:  rows[0] = data;
        gf3nc_pkg::REG_COEF_ROW1:  rows[1] = data;
        gf3nc_pkg::REG_COEF_ROW2:  rows[2] = data;
        default: ;
      endcase
    endfunction

    // shift-and-add product, reduced by x^8 + poly whether or not irreducible
    function logic [gf3nc_pkg::SymW-1:0] gf_product(logic [gf3nc_pkg::SymW-1:0] coef,
                                                    logic [gf3nc_pkg::SymW-1:0] sym);
      logic [gf3nc_pkg::SymW-1:0] acc;
      logic [gf3nc_pkg::SymW-1:0] x;
      acc = '0;
      x   = sym;
      for (int k = 0; k < gf3nc_pkg::SymW; k++) begin
        if (coef[k]) acc ^= x;
        x = x[gf3nc_pkg::SymW-1] ? ({x[gf3nc_pkg::SymW-2:0], 1'b0} ^ poly)
                                 : {x[gf3nc_pkg::SymW-2:0], 1'b0};
      end
      return acc;
    endfunction

    function logic [gf3nc_pkg::SymW-1:0] row_dot(gf3nc_pkg::coef_row_t r,
                                                 gf3nc_pkg::in_item_t s);
      return gf_product(r.c0, s.byte_a) ^ gf_product(r.c1, s.byte_b)
           ^ gf_product(r.c2, s.byte_c);
    endfunction

    function void absorb_sources(gf3nc_pkg::in_item_t s);
      gf3nc_pkg::out_item_t e;
      e.coded_a  = row_dot(rows[0], s);
      e.coded_b  = row_dot(rows[1], s);
      e.coded_c  = row_dot(rows[2], s);
      e.last_out = s.last_in;
      coded_q = {coded_q, e};
    endfunction

    function void check_field(string name, logic [gf3nc_pkg::SymW-1:0] want,
                              logic [gf3nc_pkg::SymW-1:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t ns: %s mismatch, expected %02h actual %02h", $time, name, want, got);
      end
    endfunction

    function void compare_coded(gf3nc_pkg::out_item_t got);
      gf3nc_pkg::out_item_t want;
      if (coded_q.size() == 0) begin
        errors++;
        $display("%0t ns: coded item with none pending, expected none actual %h", $time, got);
        return;
      end
      want = coded_q.pop_front();
      checked++;
      check_field("coded_a", want.coded_a, got.coded_a);
      check_field("coded_b", want.coded_b, got.coded_b);
      check_field("coded_c", want.coded_c, got.coded_c);
      check_field("last_out", gf3nc_pkg::SymW'(want.last_out),
                  gf3nc_pkg::SymW'(got.last_out));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, DUT hookup
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  logic                            cfg_we;
  logic [gf3nc_pkg::CfgIdxW-1:0]   cfg_idx;
  logic [gf3nc_pkg::RowW-1:0]      cfg_data;
  logic                            in_valid;
  logic                            in_ready;
  gf3nc_pkg::in_item_t             in_data;
  logic                            out_valid;
  logic                            out_ready;
  gf3nc_pkg::out_item_t            out_data;

  gf256_three_symbol_network_coder_top u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  gf3_coder_mirror board;

  int unsigned send_idle_pct = 0;  // chance in 100 the sender skips a cycle
  int unsigned recv_idle_pct = 0;  // chance in 100 the receiver deasserts ready
  int unsigned rx_hold_left  = 0;  // forced receiver stall, counted down below
  int unsigned stalled       = 0;
  int unsigned sources_taken = 0;
  int unsigned packets_done  = 0;
  int unsigned settings_used = 0;

  // --------------------------------------------------------------------------
  // Receiver: ready changes on the falling edge. A pending hold request wins
  // over random idling and is counted down here, so the sender keeps pushing
  // until the two-entry pipeline fills and in_ready drops.
  // --------------------------------------------------------------------------
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: handshakes sampled at the rising edge, before the DUT's registers
  // update. Inputs feed the mirror, results are checked against it. The
  // watchdog trips on a long run of cycles with no handshake on either side.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        board.absorb_sources(in_data);
        sources_taken++;
        if (in_data.last_in) packets_done++;
      end
      if (out_valid && out_ready) board.compare_coded(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stalled = 0;
      end else begin
        stalled++;
        if (stalled >= StallLimit) begin
          $display("%0t ns: watchdog, no handshake for %0d cycles", $time, stalled);
          $display("DONE: errors detected");
          $finish;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  function automatic gf3nc_pkg::in_item_t make_sym(logic [gf3nc_pkg::SymW-1:0] a,
                                                   logic [gf3nc_pkg::SymW-1:0] b,
                                                   logic [gf3nc_pkg::SymW-1:0] c,
                                                   logic last);
    gf3nc_pkg::in_item_t s;
    s.byte_a  = a;
    s.byte_b  = b;
    s.byte_c  = c;
    s.last_in = last;
    return s;
  endfunction

  // byte with extra weight on the all-zero, all-one and 0x80 corners
  function automatic logic [gf3nc_pkg::SymW-1:0] rand_byte();
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      2:       return 8'h80;
      default: return gf3nc_pkg::SymW'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [gf3nc_pkg::RowW-1:0] rand_row();
    gf3nc_pkg::coef_row_t r;
    r.c0 = ($urandom_range(5) == 0) ? 8'h01 : rand_byte();
    r.c1 = ($urandom_range(5) == 0) ? 8'h01 : rand_byte();
    r.c2 = ($urandom_range(5) == 0) ? 8'h01 : rand_byte();
    return r;
  endfunction

  // Offer one item; valid stays high after acceptance so back-to-back items
  // need no toggle. Random gaps drop valid for whole cycles only.
  task automatic push_symbols(input gf3nc_pkg::in_item_t item);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop offering and wait for every predicted item, plus the pipeline depth.
  task automatic drain_coder();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.coded_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [gf3nc_pkg::CfgIdxW-1:0] idx,
                           input logic [gf3nc_pkg::RowW-1:0] data);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    board.write_reg(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // poly goes out with junk in the upper bits, which the block must drop
  task automatic load_matrix(input logic [gf3nc_pkg::SymW-1:0] poly,
                             input logic [gf3nc_pkg::RowW-1:0] r0,
                             input logic [gf3nc_pkg::RowW-1:0] r1,
                             input logic [gf3nc_pkg::RowW-1:0] r2);
    write_reg(gf3nc_pkg::REG_FIELD_POLY, {16'($urandom_range(16'hffff)), poly});
    write_reg(gf3nc_pkg::REG_COEF_ROW0, r0);
    write_reg(gf3nc_pkg::REG_COEF_ROW1, r1);
    write_reg(gf3nc_pkg::REG_COEF_ROW2, r2);
    settings_used++;
  endtask

  // Random traffic: packets of 1..16 offsets, last set on the final one.
  // Each chunk gets a fresh matrix; the first two chunks of a phase pin the
  // polynomial to its extremes, the rest mix common and random values.
  task automatic run_phase(input int unsigned s_pct, input int unsigned r_pct,
                           input int unsigned chunks);
    int unsigned left;
    int unsigned len;
    logic [gf3nc_pkg::SymW-1:0] poly;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int unsigned ch = 0; ch < chunks; ch++) begin
      drain_coder();
      case (ch)
        0: poly = 8'h00;
        1: poly = 8'hff;
        default: begin
          case ($urandom_range(3))
            0:       poly = 8'h1d;
            1:       poly = 8'h1b;
            default: poly = gf3nc_pkg::SymW'($urandom_range(255));
          endcase
        end
      endcase
      load_matrix(poly, rand_row(), rand_row(), rand_row());
      // long receiver stall while the sender keeps offering
      if (ch == 0) rx_hold_left = HoldCycles;
      left = ChunkItems;
      while (left > 0) begin
        len = $urandom_range(16, 1);
        if (len > left) len = left;
        for (int unsigned i = 0; i < len; i++) begin
          push_symbols(make_sym(rand_byte(), rand_byte(), rand_byte(), i == len - 1));
        end
        left -= len;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    board    = new();
    rst_n    = 1'b0;
    cfg_we   = 1'b0;
    cfg_idx  = gf3nc_pkg::REG_FIELD_POLY;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // reset matrix is identity: bytes pass straight through
    push_symbols(make_sym(8'h00, 8'h00, 8'h00, 1'b0));
    push_symbols(make_sym(8'hff, 8'hff, 8'hff, 1'b1));
    push_symbols(make_sym(8'h80, 8'h01, 8'hff, 1'b0));
    push_symbols(make_sym(8'h5a, 8'ha5, 8'h3c, 1'b1));
    drain_coder();

    // writes to unused indexes must leave the matrix alone
    for (int i = RegSpareLo; i < 2 ** gf3nc_pkg::CfgIdxW; i++) begin
      write_reg(gf3nc_pkg::CfgIdxW'(i), '1);
    end
    push_symbols(make_sym(8'h12, 8'h34, 8'h56, 1'b1));
    drain_coder();

    // zero row, all-ones row, mixed row
    load_matrix(8'h1b, 24'h000000, 24'hffffff, 24'h028053);
    push_symbols(make_sym(8'hff, 8'hff, 8'hff, 1'b0));
    push_symbols(make_sym(8'h80, 8'h80, 8'h80, 1'b1));
    push_symbols(make_sym(8'h01, 8'h02, 8'h04, 1'b0));
    push_symbols(make_sym(8'h00, 8'hff, 8'h00, 1'b1));
    drain_coder();

    // reducible polynomial at its low extreme: overflow bits simply vanish
    load_matrix(8'h00, 24'h808080, 24'h010203, 24'hff0001);
    push_symbols(make_sym(8'hff, 8'h80, 8'h7f, 1'b0));
    push_symbols(make_sym(8'h80, 8'hff, 8'h01, 1'b1));
    push_symbols(make_sym(8'hc3, 8'h3c, 8'h99, 1'b0));
    drain_coder();

    // polynomial at its high extreme
    load_matrix(8'hff, 24'hff8002, 24'h02ff80, 24'h8002ff);
    push_symbols(make_sym(8'hff, 8'hff, 8'hff, 1'b1));
    push_symbols(make_sym(8'h80, 8'h40, 8'h20, 1'b0));
    push_symbols(make_sym(8'h01, 8'hff, 8'h80, 1'b1));
    drain_coder();

    // back to the usual field with a dense matrix
    load_matrix(8'h1d, 24'h020301, 24'h010203, 24'h030102);
    push_symbols(make_sym(8'hfe, 8'h7f, 8'h01, 1'b0));
    push_symbols(make_sym(8'h80, 8'h00, 8'hff, 1'b1));

    // random: sender-light/receiver-heavy idling, then swapped, then none
    run_phase(30, 81, 6);
    run_phase(81, 30, 6);
    run_phase(0, 0, 6);

    drain_coder();
    repeat (4) @(posedge clk);
    board.errors += board.coded_q.size();

    $display("Coded %0d source offsets in %0d packets across %0d matrix/polynomial settings,",
             sources_taken, packets_done, settings_used);
    $display("checked %0d results under random and forced stalls; %0d mismatches.",
             board.checked, board.errors);
    if (board.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/gf3nc_pkg.sv
hdl/gf3nc_mul.sv
hdl/gf3nc_row.sv
hdl/gf256_three_symbol_network_coder_top.sv
hdl/gf3nc_checker.sv
tb/tb_gf256_three_symbol_network_coder_top.sv
